// File: design/sktp_pkg.sv
package sktp_pkg;

    typedef struct packed {
        logic [7:0] key_char;
        logic       key_last;
        logic       create_if_absent;
    } t_in_item;

    typedef struct packed {
        logic [9:0] slot_index;
        logic [2:0] status;
    } t_out_item;

    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_ABSENT   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_TOOLONG  = 3'd4;

    localparam int HASH_W = 32;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_OUT
    } t_back_state;

endpackage

// File: design/sktp_queue.sv
module sktp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_not_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full      = (r_cnt == 2'd2);
    assign o_not_empty = (r_cnt != 2'd0);
    assign o_data      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

// File: design/sktp_front.sv
module sktp_front #(
    parameter int KEY_CHARS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sktp_pkg::t_in_item   i_in_data,
    input  logic                 i_clearing,
    input  logic                 i_q_full,
    output logic                 o_push,
    output logic [8*KEY_CHARS+$clog2(KEY_CHARS+2)+sktp_pkg::HASH_W:0] o_job
);
    import sktp_pkg::*;

    localparam int LW = $clog2(KEY_CHARS + 2);
    localparam int IW = $clog2(KEY_CHARS);

    logic [7:0]        r_key [KEY_CHARS];
    logic [7:0]        n_key [KEY_CHARS];
    logic [LW-1:0]     r_len;
    logic [LW-1:0]     n_len;
    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] n_hash;
    logic [8*KEY_CHARS-1:0] key_vec;
    logic              accept;

    assign o_in_stall = i_q_full || i_clearing;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = accept && i_in_data.key_last;

    always_comb begin
        n_key  = r_key;
        n_len  = r_len;
        n_hash = r_hash;
        if (i_in_data.key_char != 8'd0) begin
            n_hash = (r_hash << 1) + r_hash + HASH_W'(i_in_data.key_char);
            if (r_len < LW'(KEY_CHARS)) n_key[r_len[IW-1:0]] = i_in_data.key_char;
            if (r_len <= LW'(KEY_CHARS)) n_len = r_len + LW'(1);
        end
        for (int i = 0; i < KEY_CHARS; i++) key_vec[8*i +: 8] = n_key[i];
    end

    assign o_job = {i_in_data.create_if_absent, n_len, n_hash, key_vec};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_hash <= '0;
        end else if (accept) begin
            r_len  <= i_in_data.key_last ? '0 : n_len;
            r_hash <= i_in_data.key_last ? '0 : n_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_key <= n_key;
    end
endmodule

// File: design/sktp_back.sv
module sktp_back #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int KEY_CHARS     = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_not_empty,
    output logic                 o_pop,
    input  logic [8*KEY_CHARS+$clog2(KEY_CHARS+2)+sktp_pkg::HASH_W:0] i_job,
    output logic                 o_clearing,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sktp_pkg::t_out_item  o_out_data
);
    import sktp_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int LW = $clog2(KEY_CHARS + 2);
    localparam int RW = 8 * KEY_CHARS;
    // reciprocal of TABLE_ENTRIES, exact for any dividend below 2^(HASH_W-1)
    localparam int SH = HASH_W - 1 + $clog2(TABLE_ENTRIES);
    localparam logic [2*HASH_W-1:0] RECIP =
        ((64'd1 << SH) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);

    logic [RW-1:0] mem [TABLE_ENTRIES];
    logic [RW-1:0] r_rdata;

    t_back_state   r_state, n_state;
    logic [HASH_W-1:0] r_div, n_div;
    logic [2*HASH_W-1:0] r_prod, n_prod;
    logic          r_step, n_step;
    logic [AW-1:0] r_slot, n_slot;
    logic [AW:0]   r_n, n_n;
    logic [LW-1:0] r_len, n_len;
    logic          r_create, n_create;
    logic [RW-1:0] r_key, n_key;
    logic [AW-1:0] r_used, n_used;
    logic [2:0]    r_status, n_status;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out_data, n_out_data;

    logic [HASH_W-1:0] job_hash;
    logic [LW-1:0] job_len;
    logic [HASH_W-1:0] hash_abs;
    logic [HASH_W-1:0] quot;
    logic [HASH_W-1:0] rem_full;
    logic [AW-1:0] slot_next;
    logic          row_empty;
    logic          row_match;
    logic [RW-1:0] key_masked;
    logic          we;
    logic [RW-1:0] wdata;

    assign job_hash = i_job[RW +: HASH_W];
    assign job_len  = i_job[RW+HASH_W +: LW];
    assign hash_abs = job_hash[HASH_W-1] ? ~job_hash : job_hash;
    assign quot     = HASH_W'(r_prod >> SH);
    assign rem_full = r_div - quot * HASH_W'(TABLE_ENTRIES);
    assign slot_next = (r_slot == AW'(TABLE_ENTRIES - 1)) ? '0 : r_slot + AW'(1);
    assign row_empty = (r_rdata[7:0] == 8'd0);

    always_comb begin
        row_match = 1'b1;
        for (int i = 0; i < KEY_CHARS; i++) begin
            key_masked[8*i +: 8] = (LW'(i) < r_len) ? r_key[8*i +: 8] : 8'd0;
            if (r_rdata[8*i +: 8] != key_masked[8*i +: 8]) row_match = 1'b0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_div       = r_div;
        n_prod      = r_prod;
        n_step      = r_step;
        n_slot      = r_slot;
        n_n         = r_n;
        n_len       = r_len;
        n_create    = r_create;
        n_key       = r_key;
        n_used      = r_used;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        we          = 1'b0;
        wdata       = key_masked;
        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                wdata = '0;
                n_slot = r_slot + AW'(1);
                if (r_slot == AW'(TABLE_ENTRIES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_q_not_empty) begin
                    o_pop    = 1'b1;
                    n_len    = job_len;
                    n_create = i_job[RW+HASH_W+LW];
                    n_key    = i_job[RW-1:0];
                    n_div    = hash_abs;
                    n_step   = 1'b0;
                    n_slot   = '0;
                    n_n      = '0;
                    if (job_len > LW'(KEY_CHARS)) begin
                        n_status = ST_TOOLONG;
                        n_state  = S_OUT;
                    end else if (job_len == '0) begin
                        n_status = ST_ABSENT;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (!r_step) begin
                    n_prod = r_div * RECIP[HASH_W-1:0];
                    n_step = 1'b1;
                end else begin
                    n_slot  = AW'(rem_full);
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (row_empty) begin
                    if (!r_create) begin
                        n_status = ST_ABSENT;
                        n_slot   = '0;
                        n_state  = S_OUT;
                    end else if (r_used >= AW'(TABLE_ENTRIES - 1)) begin
                        n_status = ST_FULL;
                        n_slot   = '0;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_WRITE;
                    end
                end else if (row_match) begin
                    n_status = ST_FOUND;
                    n_state  = S_OUT;
                end else if (r_n + (AW+1)'(1) == (AW+1)'(TABLE_ENTRIES)) begin
                    n_status = r_create ? ST_FULL : ST_ABSENT;
                    n_slot   = '0;
                    n_state  = S_OUT;
                end else begin
                    n_n     = r_n + (AW+1)'(1);
                    n_slot  = slot_next;
                    n_state = S_READ;
                end
            end
            S_WRITE: begin
                we       = 1'b1;
                n_used   = r_used + AW'(1);
                n_status = ST_INSERTED;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid           = 1'b1;
                    n_out_data.slot_index = 10'(r_slot);
                    n_out_data.status     = r_status;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_slot      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div      <= n_div;
        r_prod     <= n_prod;
        r_step     <= n_step;
        r_n        <= n_n;
        r_len      <= n_len;
        r_create   <= n_create;
        r_key      <= n_key;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[r_slot] <= wdata;
        r_rdata <= mem[r_slot];
    end

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule

// File: design/string_key_hash_table_probe_top.sv
// Symbol table: open-addressed hash table with linear probing. Keys arrive one
// character per transfer. A final character queues the key (two-deep queue) for
// the lookup engine, which takes the key from the queue, reduces the hash modulo
// TABLE_ENTRIES (reciprocal multiply, then multiply back and subtract), reads
// and then checks each probed slot (one read port on the name store), stores a
// new name on an insert and loads the result register; an empty or overlong key
// goes straight to the result register. The engine takes no new key until its
// result is loaded, and a stalled result holds the engine. After reset the name
// store is cleared one slot per cycle, and input is stalled while it clears.
module string_key_hash_table_probe_top #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int KEY_CHARS     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sktp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sktp_pkg::t_out_item o_out_data
);
    import sktp_pkg::*;

    localparam int JW = 8 * KEY_CHARS + $clog2(KEY_CHARS + 2) + HASH_W + 1;

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_not_empty;
    logic          clearing;
    logic [JW-1:0] job_in;
    logic [JW-1:0] job_out;

    sktp_front #(.KEY_CHARS(KEY_CHARS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (job_in)
    );

    sktp_queue #(.WIDTH(JW)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (job_in),
        .i_pop       (pop),
        .o_data      (job_out),
        .o_full      (q_full),
        .o_not_empty (q_not_empty)
    );

    sktp_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .KEY_CHARS(KEY_CHARS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .o_pop         (pop),
        .i_job         (job_out),
        .o_clearing    (clearing),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );
endmodule

// File: design/sktp_checker.sv
module sktp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input sktp_pkg::t_out_item o_out_data
);
    import sktp_pkg::*;

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status <= ST_TOOLONG))
        else $error("status out of range");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_FOUND
         && o_out_data.status != ST_INSERTED) |-> (o_out_data.slot_index == 10'd0))
        else $error("nonzero slot on a miss");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");
endmodule

bind string_key_hash_table_probe_top sktp_checker u_sktp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: sim/tb_top.sv
module tb_top;
    import sktp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TE = 1024;
    localparam int KC = 16;
    localparam int POOL = 64;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    string_key_hash_table_probe_top #(.TABLE_ENTRIES(TE), .KEY_CHARS(KC)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // symbol table shadow
    logic [7:0]  names [0:TE*KC-1];
    logic [7:0]  key_buf [0:KC-1];
    int unsigned key_len;
    logic [31:0] hash_acc;
    int unsigned names_used;

    t_in_item  char_q [$];
    t_out_item lookup_q [$];

    int errors = 0;
    int n_results = 0;
    int n_chars = 0;
    int st_count [0:7];
    bit quiet = 1'b0;
    bit hold_start = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int in_gap = 0;
    int out_gap = 0;

    logic [7:0] kw [0:19];
    logic [7:0] pool [0:POOL-1][0:19];
    int         pool_len [0:POOL-1];
    int         pool_cnt = 0;
    int         pushed = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %0s: got %0d, expected %0d (result %0d)", what, got, want, n_results);
        errors++;
    endtask

    function automatic bit name_matches(input int unsigned slot, input int unsigned len);
        bit m;
        m = 1'b1;
        for (int i = 0; i < len; i++)
            if (names[slot*KC+i] != key_buf[i]) m = 1'b0;
        if (len < KC && names[slot*KC+len] != 8'd0) m = 1'b0;
        return m;
    endfunction

    task automatic lookup_char(input t_in_item it);
        int unsigned len;
        int unsigned slot;
        logic [31:0] h;
        bit found;
        bit empty;
        t_out_item r;
        found = 1'b0;
        empty = 1'b0;
        if (it.key_char != 8'd0) begin
            hash_acc = hash_acc * 3 + it.key_char;
            if (key_len < KC) key_buf[key_len] = it.key_char;
            if (key_len <= KC) key_len++;
        end
        if (!it.key_last) return;
        len = key_len;
        h = hash_acc;
        key_len = 0;
        hash_acc = '0;
        r = '0;
        if (len > KC) begin
            r.status = ST_TOOLONG;
        end else if (len == 0) begin
            r.status = ST_ABSENT;
        end else begin
            if (h[31]) h = ~h;
            slot = h % TE;
            for (int n = 0; n < TE; n++) begin
                if (names[slot*KC] == 8'd0) begin
                    empty = 1'b1;
                    break;
                end
                if (name_matches(slot, len)) begin
                    found = 1'b1;
                    break;
                end
                slot = (slot + 1 == TE) ? 0 : slot + 1;
            end
            if (found) begin
                r.slot_index = slot[9:0];
                r.status = ST_FOUND;
            end else if (!it.create_if_absent) begin
                r.status = ST_ABSENT;
            end else if (!empty || names_used >= TE - 1) begin
                r.status = ST_FULL;
            end else begin
                for (int i = 0; i < KC; i++)
                    names[slot*KC+i] = (i < len) ? key_buf[i] : 8'd0;
                names_used++;
                r.slot_index = slot[9:0];
                r.status = ST_INSERTED;
            end
        end
        lookup_q.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                lookup_char(i_in_data);
                n_chars++;
            end
            if (i_in_valid && o_in_stall) begin
                i_in_valid <= 1'b1;
            end else if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (char_q.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
                in_gap = $urandom_range(1, 14) - 1;
                i_in_valid <= 1'b0;
            end else if (char_q.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data <= char_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_start && !hold_taken) begin
            hold_left <= 400;
            hold_taken <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (lookup_q.size() == 0) begin
                    report("unexpected result, status", o_out_data.status, -1);
                end else begin
                    want = lookup_q.pop_front();
                    st_count[want.status]++;
                    if (o_out_data.slot_index !== want.slot_index)
                        report("slot_index", o_out_data.slot_index, want.slot_index);
                    if (o_out_data.status !== want.status)
                        report("status", o_out_data.status, want.status);
                end
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_gap = $urandom_range(1, 14) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_key(input int n, input bit create);
        t_in_item it;
        if (n == 0) begin
            it = '{key_char: 8'd0, key_last: 1'b1, create_if_absent: create};
            char_q.push_back(it);
            pushed++;
        end
        for (int i = 0; i < n; i++) begin
            it.key_char = kw[i];
            it.key_last = (i == n - 1);
            it.create_if_absent = (i == n - 1) ? create : 1'($urandom_range(0, 1));
            char_q.push_back(it);
            pushed++;
        end
    endtask

    task automatic make_key(input int n);
        for (int i = 0; i < n; i++) kw[i] = 8'($urandom_range(1, 255));
    endtask

    task automatic keep_key(input int n);
        for (int i = 0; i < n; i++) pool[pool_cnt % POOL][i] = kw[i];
        pool_len[pool_cnt % POOL] = n;
        pool_cnt++;
    endtask

    task automatic recall_key(output int n);
        int k;
        k = $urandom_range(0, ((pool_cnt < POOL) ? pool_cnt : POOL) - 1);
        n = pool_len[k];
        for (int i = 0; i < n; i++) kw[i] = pool[k][i];
    endtask

    task automatic drain();
        while (char_q.size() > 0 || i_in_valid || lookup_q.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        int n;
        int r;
        t_in_item it;
        for (int i = 0; i < TE*KC; i++) names[i] = 8'd0;
        for (int i = 0; i < 8; i++) st_count[i] = 0;
        key_len = 0;
        hash_acc = '0;
        names_used = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_key(0, 1'b1);
        kw[0] = 8'h01;
        send_key(1, 1'b0);
        send_key(1, 1'b1);
        send_key(1, 1'b0);
        kw[0] = 8'hFF; kw[1] = 8'h80;
        send_key(2, 1'b1);
        send_key(1, 1'b0);
        kw[0] = 8'h78;
        char_q.push_back('{key_char: 8'h78, key_last: 1'b0, create_if_absent: 1'b0});
        char_q.push_back('{key_char: 8'h00, key_last: 1'b1, create_if_absent: 1'b1});
        send_key(1, 1'b0);
        for (int i = 0; i < 17; i++) kw[i] = 8'hFF - i;
        send_key(17, 1'b1);
        drain();

        // random keys, first with the output held off
        hold_start <= 1'b1;
        pushed = 0;
        while (pushed < 540) begin
            r = $urandom_range(0, 99);
            if (r < 50 || pool_cnt == 0) begin
                n = (r < 5) ? KC : $urandom_range(1, 6);
                make_key(n);
                send_key(n, 1'($urandom_range(0, 1)));
                keep_key(n);
            end else if (r < 80) begin
                recall_key(n);
                send_key(n, 1'($urandom_range(0, 1)));
            end else if (r < 85) begin
                recall_key(n);
                if (n > 1) send_key(n - 1, 1'b0);
            end else if (r < 90) begin
                n = $urandom_range(KC + 1, 20);
                make_key(n);
                send_key(n, 1'($urandom_range(0, 1)));
            end else if (r < 94) begin
                send_key(0, 1'($urandom_range(0, 1)));
            end else begin
                it = '{key_char: 8'd0, key_last: 1'b0, create_if_absent: 1'($urandom_range(0, 1))};
                char_q.push_back(it);
            end
            if (pushed >= 350 && pushed < 360) drain();
        end
        drain();

        quiet = 1'b1;
        for (int b = 0; b < 30; b++) begin
            if (b % 3 == 0) begin
                make_key(5);
                send_key(5, 1'b1);
            end else begin
                recall_key(n);
                send_key(n, 1'($urandom_range(0, 1)));
            end
        end
        drain();
        repeat (300) @(posedge i_clk);

        $display("%0d characters sent, %0d lookups checked, %0d names stored", n_chars,
                 n_results, names_used);
        $display("found %0d, inserted %0d, absent %0d, full %0d, too long %0d", st_count[0],
                 st_count[1], st_count[2], st_count[3], st_count[4]);
        if (errors == 0 && lookup_q.size() == 0)
            $display("** string_key_hash_table_probe_top: PASSED **");
        else
            $display("** string_key_hash_table_probe_top: FAILED **");
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("** string_key_hash_table_probe_top: FAILED **");
        $finish;
    end

endmodule
